>>> rtl/core/ufx_pkg.sv
// ----------------------------------------------------------------------------
// ufx_pkg
// Types, codes and helpers shared by the form field extractor modules.
// ----------------------------------------------------------------------------
package ufx_pkg;

  // Raw and decoded characters with special meaning.
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_PERCENT = 8'h25;
  localparam logic [7:0] CHAR_EQUALS  = 8'h3D;
  localparam logic [7:0] CHAR_AMP     = 8'h26;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_NUL     = 8'h00;

  // Configuration register indexes.
  localparam logic CFG_FIRST_NAME  = 1'b0;
  localparam logic CFG_SECOND_NAME = 1'b1;

  // Reset names: "username" and "password".
  localparam logic [63:0] FIRST_NAME_RST  = 64'h7573_6572_6E61_6D65;
  localparam logic [63:0] SECOND_NAME_RST = 64'h7061_7373_776F_7264;

  // Reject reasons.
  localparam logic REJ_KEY_LEN  = 1'b0;
  localparam logic REJ_NO_VALUE = 1'b1;

  // Maximum number of results one input byte can cause.
  localparam int unsigned MAX_RES = 3;

  typedef enum logic [1:0] {
    KIND_BYTE   = 2'd0,
    KIND_END    = 2'd1,
    KIND_ACCEPT = 2'd2,
    KIND_REJECT = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ESC_IDLE = 2'd0,
    ESC_HIGH = 2'd1,
    ESC_LOW  = 2'd2
  } esc_e;

  typedef enum logic [1:0] {
    PAIR_START = 2'd0,
    PAIR_KEY   = 2'd1,
    PAIR_EQ    = 2'd2,
    PAIR_VALUE = 2'd3
  } pair_e;

  typedef enum logic [1:0] {
    MATCH_NONE   = 2'd0,
    MATCH_FIRST  = 2'd1,
    MATCH_SECOND = 2'd2
  } match_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data_byte;
    logic       field_id;
    logic       reject_code;
    logic       last;
  } res_t;

  // Results caused by one input byte, in order.
  typedef struct packed {
    logic [1:0]           cnt;
    res_t [MAX_RES-1:0]   res;
  } pkt_t;

  // Hex digit value; only 0-9 and A-F count, anything else is zero.
  function automatic logic [3:0] hex_value(input logic [7:0] b);
    logic [7:0] v;
    begin
      v = 8'h00;
      if (b >= 8'h30 && b <= 8'h39) begin
        v = b - 8'h30;
      end else if (b >= 8'h41 && b <= 8'h46) begin
        v = b - 8'h37;
      end
      return v[3:0];
    end
  endfunction

  function automatic res_t mk_res(input kind_e kind, input logic [7:0] data,
                                  input logic fid, input logic code,
                                  input logic last);
    res_t r;
    begin
      r.kind        = kind;
      r.data_byte   = data;
      r.field_id    = fid;
      r.reject_code = code;
      r.last        = last;
      return r;
    end
  endfunction

  // Append one result to a packet.
  function automatic pkt_t push(input pkt_t p, input res_t r);
    pkt_t o;
    begin
      o = p;
      if (p.cnt != 2'(MAX_RES)) begin
        o.res[p.cnt] = r;
        o.cnt        = p.cnt + 2'd1;
      end
      return o;
    end
  endfunction

endpackage

>>> rtl/core/urlencoded_form_field_extractor.sv
// ----------------------------------------------------------------------------
// urlencoded_form_field_extractor
// Decodes a url-encoded form body and emits the values of two named keys.
//
// Input channel (in_valid_i/in_ready_o): one raw body byte per request, with
// in_last_i on the final byte of a message. Output channel
// (out_valid_o/out_ready_i): one result per request: a value byte, a value
// end, or the closing accept/reject with out_last_o set.
// Configuration: cfg_we_i writes cfg_data_i to name register cfg_index_i
// (0 first name, 1 second name); write only while the block is idle.
// Registered output: a byte's first result shows in the cycle after its accept.
// Throughput: one byte per cycle while out_ready_i is high and each byte causes
// at most one result; a byte with more results holds the input side until its
// last result leaves the result register, which drains one per ready cycle.
// Reset: parser state clears and the names return to "username" and
// "password"; no result is pending.
// Stall: when out_ready_i is low the result register holds, and the input
// side stops taking bytes until its last pending result leaves.
// ----------------------------------------------------------------------------
module urlencoded_form_field_extractor import ufx_pkg::*; #(
  parameter int unsigned KEY_LEN = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        in_last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  data_byte_o,
  output logic        field_id_o,
  output logic        reject_code_o,
  output logic        out_last_o,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  localparam int unsigned KEY_W = 8 * KEY_LEN;

  logic [63:0] first_name_q;
  logic [63:0] second_name_q;
  logic        take;
  logic        can_load;
  pkt_t        pkt;
  res_t        res;

  // Name registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_name_q  <= FIRST_NAME_RST;
      second_name_q <= SECOND_NAME_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_FIRST_NAME:  first_name_q  <= cfg_data_i;
        CFG_SECOND_NAME: second_name_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_ready_o = can_load;
  assign take       = in_valid_i && can_load;

  ufx_step #(
    .KEY_LEN (KEY_LEN)
  ) u_step (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (take),
    .in_byte_i     (in_byte_i),
    .in_last_i     (in_last_i),
    .first_name_i  (first_name_q[KEY_W-1:0]),
    .second_name_i (second_name_q[KEY_W-1:0]),
    .pkt_o         (pkt)
  );

  ufx_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (take),
    .pkt_i       (pkt),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign kind_o        = res.kind;
  assign data_byte_o   = res.data_byte;
  assign field_id_o    = res.field_id;
  assign reject_code_o = res.reject_code;
  assign out_last_o    = res.last;

endmodule

>>> rtl/core/ufx_step.sv
// ----------------------------------------------------------------------------
// ufx_step
// Per-message parser state: escape decoding, key/value tracking and the
// results caused by each accepted byte.
// ----------------------------------------------------------------------------
module ufx_step import ufx_pkg::*; #(
  parameter int unsigned KEY_LEN = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 take_i,
  input  logic [7:0]           in_byte_i,
  input  logic                 in_last_i,
  input  logic [8*KEY_LEN-1:0] first_name_i,
  input  logic [8*KEY_LEN-1:0] second_name_i,
  output pkt_t                 pkt_o
);

  localparam int unsigned KEY_W = 8 * KEY_LEN;

  esc_e             esc_q, esc_d;
  logic [3:0]       hn_q, hn_d;
  pair_e            pair_q, pair_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [3:0]       kcnt_q, kcnt_d;
  match_e           match_q, match_d;
  logic             fin_q, fin_d;

  logic             dlv;
  logic [7:0]       dbyte;
  logic             end_now;
  pkt_t             pkt;

  // Decode, split into pairs and collect the results for this byte.
  always_comb begin
    esc_d   = esc_q;
    hn_d    = hn_q;
    pair_d  = pair_q;
    key_d   = key_q;
    kcnt_d  = kcnt_q;
    match_d = match_q;
    fin_d   = fin_q;
    dlv     = 1'b0;
    dbyte   = in_byte_i;
    end_now = 1'b0;
    pkt     = '0;

    if (!fin_q) begin
      // Escape decoding turns the raw byte into at most one decoded byte.
      if (esc_q == ESC_HIGH) begin
        hn_d  = hex_value(in_byte_i);
        esc_d = ESC_LOW;
      end else if (esc_q == ESC_LOW) begin
        esc_d = ESC_IDLE;
        dlv   = 1'b1;
        dbyte = {hn_q, hex_value(in_byte_i)};
      end else if (in_byte_i == CHAR_PLUS) begin
        dlv   = 1'b1;
        dbyte = CHAR_SPACE;
      end else if (in_byte_i == CHAR_PERCENT) begin
        esc_d = ESC_HIGH;
      end else begin
        dlv = 1'b1;
      end

      // Pair tracking for a nonzero decoded byte.
      if (dlv && dbyte != CHAR_NUL) begin
        case (pair_q)
          PAIR_START: begin
            key_d   = KEY_W'(dbyte);
            kcnt_d  = 4'd1;
            match_d = MATCH_NONE;
            pair_d  = PAIR_KEY;
          end
          PAIR_KEY: begin
            if (dbyte == CHAR_EQUALS) begin
              if (kcnt_q != 4'(KEY_LEN)) begin
                pkt   = push(pkt, mk_res(KIND_REJECT, 8'h00, 1'b0, REJ_KEY_LEN, 1'b1));
                fin_d = 1'b1;
              end else begin
                if (key_q == first_name_i) begin
                  match_d = MATCH_FIRST;
                end else if (key_q == second_name_i) begin
                  match_d = MATCH_SECOND;
                end else begin
                  match_d = MATCH_NONE;
                end
                pair_d = PAIR_EQ;
              end
            end else begin
              key_d = KEY_W'({key_q, dbyte});
              if (kcnt_q != 4'd15) begin
                kcnt_d = kcnt_q + 4'd1;
              end
            end
          end
          default: begin
            if (dbyte == CHAR_AMP) begin
              if (match_q != MATCH_NONE) begin
                pkt = push(pkt, mk_res(KIND_END, 8'h00, match_q == MATCH_SECOND,
                                       1'b0, 1'b0));
              end
              match_d = MATCH_NONE;
              pair_d  = PAIR_START;
            end else begin
              pair_d = PAIR_VALUE;
              if (match_q != MATCH_NONE) begin
                pkt = push(pkt, mk_res(KIND_BYTE, dbyte, match_q == MATCH_SECOND,
                                       1'b0, 1'b0));
              end
            end
          end
        endcase
      end

      // End of message on a decoded zero or on the marked last byte.
      end_now = (dlv && dbyte == CHAR_NUL) || in_last_i;
      if (end_now && !fin_d) begin
        if (pair_d == PAIR_KEY || pair_d == PAIR_EQ) begin
          pkt = push(pkt, mk_res(KIND_REJECT, 8'h00, 1'b0, REJ_NO_VALUE, 1'b1));
        end else begin
          if (pair_d == PAIR_VALUE && match_d != MATCH_NONE) begin
            pkt = push(pkt, mk_res(KIND_END, 8'h00, match_d == MATCH_SECOND,
                                   1'b0, 1'b0));
          end
          pkt = push(pkt, mk_res(KIND_ACCEPT, 8'h00, 1'b0, 1'b0, 1'b1));
        end
        fin_d = 1'b1;
      end
    end

    // The last byte always starts a fresh message.
    if (in_last_i) begin
      esc_d   = ESC_IDLE;
      hn_d    = '0;
      pair_d  = PAIR_START;
      key_d   = '0;
      kcnt_d  = '0;
      match_d = MATCH_NONE;
      fin_d   = 1'b0;
    end
  end

  assign pkt_o = pkt;

  // State advances only on an accepted request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q   <= ESC_IDLE;
      hn_q    <= '0;
      pair_q  <= PAIR_START;
      key_q   <= '0;
      kcnt_q  <= '0;
      match_q <= MATCH_NONE;
      fin_q   <= 1'b0;
    end else if (take_i) begin
      esc_q   <= esc_d;
      hn_q    <= hn_d;
      pair_q  <= pair_d;
      key_q   <= key_d;
      kcnt_q  <= kcnt_d;
      match_q <= match_d;
      fin_q   <= fin_d;
    end
  end

endmodule

>>> rtl/core/ufx_out_buf.sv
// ----------------------------------------------------------------------------
// ufx_out_buf
// Result register: holds the results of one byte and hands them out one per
// cycle while out_ready_i is high, taking the next packet as the last one leaves.
// ----------------------------------------------------------------------------
module ufx_out_buf import ufx_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  pkt_t pkt_i,
  output logic can_load_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t res_o
);

  res_t [MAX_RES-1:0] res_q;
  logic [1:0]         cnt_q;
  logic [1:0]         idx_q;
  logic               pop;

  assign out_valid_o = (cnt_q != 2'd0);
  assign pop         = out_valid_o && out_ready_i;
  assign can_load_o  = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_ready_i);
  assign res_o       = res_q[idx_q];

  // Remaining count and read position.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      idx_q <= 2'd0;
    end else if (load_i) begin
      cnt_q <= pkt_i.cnt;
      idx_q <= 2'd0;
    end else if (pop) begin
      cnt_q <= cnt_q - 2'd1;
      idx_q <= idx_q + 2'd1;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= pkt_i.res;
    end
  end

`ifndef SYNTHESIS
  // The read position never passes the end of the packet.
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(idx_q) + 32'(cnt_q) <= 32'(MAX_RES)))
    else $error("read position beyond packet");

  // A final result is always the last one of its packet.
  a_last_is_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && res_o.last) |-> (cnt_q == 2'd1))
    else $error("final result not at end of packet");

  // A nonempty packet shows up as a request in the next cycle.
  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_i && pkt_i.cnt != 2'd0) |=> (out_valid_o && idx_q == 2'd0))
    else $error("loaded packet not presented");

  // A pop inside a packet advances to the next entry.
  a_pop_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !load_i && cnt_q > 2'd1) |=> (idx_q == $past(idx_q) + 2'd1))
    else $error("read position did not advance");
`endif

endmodule

>>> sim/ufx_field_checker.sv
// ----------------------------------------------------------------------------
// ufx_field_checker
// Predicts and checks the results of the form field extractor.
//
// Watches the byte, result and configuration ports of the extractor. Every
// accepted byte runs through a local model of the form decoder, which queues
// the value bytes, value ends and accept/reject results it must cause. Every
// accepted result is compared field by field with the oldest queued result.
// The failure count and the number of results still awaited go to the top.
// ----------------------------------------------------------------------------
module ufx_field_checker import ufx_pkg::*; #(
  parameter int unsigned KEY_LEN = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  in_byte_i,
  input  logic        in_last_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  data_byte_i,
  input  logic        field_id_i,
  input  logic        reject_code_i,
  input  logic        out_last_i,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [63:0] cfg_data_i,
  output int          fail_cnt_o,
  output int          awaiting_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Only the low KEY_LEN bytes of a key take part in the name compare.
  localparam logic [63:0] KEY_MASK = {64{1'b1}} >> (64 - 8 * KEY_LEN);

  // Local copy of the name registers and of the per-message parser state.
  logic [63:0] name_a;
  logic [63:0] name_b;
  esc_e        esc_st;
  logic [3:0]  hi_nib;
  pair_e       pair_st;
  logic [63:0] key_sr;
  logic [3:0]  key_len;
  match_e      match_st;
  logic        msg_done;

  // Results predicted but not yet seen on the output.
  res_t        field_res_q[$];
  int          item_res;
  int          fail_cnt = 0;
  int          n_awaiting = 0;
  int          n_checked = 0;

  assign fail_cnt_o = fail_cnt;
  assign awaiting_o = n_awaiting;

  // Print one line per mismatch (the first 40 only) and count them all.
  task automatic report_mismatch(input string msg);
    if (fail_cnt < 40) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    fail_cnt++;
  endtask

  // Value of a hex digit; lowercase and non-digits count as zero.
  function automatic logic [3:0] digit_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") begin
      return c[3:0];
    end else if (c >= "A" && c <= "F") begin
      return c[3:0] + 4'd9;
    end
    return 4'd0;
  endfunction

  task automatic clear_msg();
    esc_st   = ESC_IDLE;
    hi_nib   = 4'd0;
    pair_st  = PAIR_START;
    key_sr   = 64'd0;
    key_len  = 4'd0;
    match_st = MATCH_NONE;
    msg_done = 1'b0;
  endtask

  // One byte can cause at most MAX_RES results; extra ones are dropped.
  task automatic emit_res(input kind_e k, input logic [7:0] d, input logic fid,
                          input logic code, input logic fin);
    res_t r;
    r.kind        = k;
    r.data_byte   = d;
    r.field_id    = fid;
    r.reject_code = code;
    r.last        = fin;
    if (item_res < MAX_RES) begin
      field_res_q.push_back(r);
      item_res++;
    end
  endtask

  task automatic close_value();
    if (match_st != MATCH_NONE) begin
      emit_res(KIND_END, 8'd0, match_st == MATCH_SECOND, 1'b0, 1'b0);
    end
  endtask

  // Closing result: a message may not stop inside a key or right after '='.
  task automatic end_msg();
    if (pair_st == PAIR_KEY || pair_st == PAIR_EQ) begin
      emit_res(KIND_REJECT, 8'd0, 1'b0, REJ_NO_VALUE, 1'b1);
    end else begin
      if (pair_st == PAIR_VALUE) begin
        close_value();
      end
      emit_res(KIND_ACCEPT, 8'd0, 1'b0, 1'b0, 1'b1);
    end
    msg_done = 1'b1;
  endtask

  // Split decoded bytes into key=value pairs.
  task automatic split_pair(input logic [7:0] b);
    case (pair_st)
      PAIR_START: begin
        // The first byte of a pair is a key byte whatever it is.
        key_sr   = {56'd0, b};
        key_len  = 4'd1;
        match_st = MATCH_NONE;
        pair_st  = PAIR_KEY;
      end
      PAIR_KEY: begin
        if (b == CHAR_EQUALS) begin
          if (key_len != 4'(KEY_LEN)) begin
            emit_res(KIND_REJECT, 8'd0, 1'b0, REJ_KEY_LEN, 1'b1);
            msg_done = 1'b1;
          end else begin
            if ((key_sr & KEY_MASK) == (name_a & KEY_MASK)) begin
              match_st = MATCH_FIRST;
            end else if ((key_sr & KEY_MASK) == (name_b & KEY_MASK)) begin
              match_st = MATCH_SECOND;
            end else begin
              match_st = MATCH_NONE;
            end
            pair_st = PAIR_EQ;
          end
        end else begin
          key_sr = {key_sr[55:0], b};
          if (key_len < 4'd15) begin
            key_len++;
          end
        end
      end
      default: begin
        if (b == CHAR_AMP) begin
          close_value();
          match_st = MATCH_NONE;
          pair_st  = PAIR_START;
        end else begin
          pair_st = PAIR_VALUE;
          if (match_st != MATCH_NONE) begin
            emit_res(KIND_BYTE, b, match_st == MATCH_SECOND, 1'b0, 1'b0);
          end
        end
      end
    endcase
  endtask

  // A decoded zero ends the message.
  task automatic take_decoded(input logic [7:0] d);
    if (d == CHAR_NUL) begin
      end_msg();
    end else begin
      split_pair(d);
    end
  endtask

  // Decode one raw byte and queue every result it causes.
  task automatic parse_byte(input logic [7:0] b, input logic fin);
    item_res = 0;
    if (!msg_done) begin
      if (esc_st == ESC_HIGH) begin
        hi_nib = digit_of(b);
        esc_st = ESC_LOW;
      end else if (esc_st == ESC_LOW) begin
        esc_st = ESC_IDLE;
        take_decoded({hi_nib, digit_of(b)});
      end else if (b == CHAR_PLUS) begin
        take_decoded(CHAR_SPACE);
      end else if (b == CHAR_PERCENT) begin
        esc_st = ESC_HIGH;
      end else begin
        take_decoded(b);
      end
      // A pending escape is simply dropped here.
      if (fin && !msg_done) begin
        end_msg();
      end
    end
    if (fin) begin
      clear_msg();
    end
  endtask

  task automatic check_result();
    res_t w;
    if (field_res_q.size() == 0) begin
      report_mismatch($sformatf("result %0d (kind %0d) with none expected",
                                n_checked, kind_i));
    end else begin
      w = field_res_q.pop_front();
      if (kind_i != w.kind) begin
        report_mismatch($sformatf("result %0d: kind %0d, expected %0d",
                                  n_checked, kind_i, w.kind));
      end
      if (data_byte_i != w.data_byte) begin
        report_mismatch($sformatf("result %0d: data_byte %02h, expected %02h",
                                  n_checked, data_byte_i, w.data_byte));
      end
      if (field_id_i != w.field_id) begin
        report_mismatch($sformatf("result %0d: field_id %0d, expected %0d",
                                  n_checked, field_id_i, w.field_id));
      end
      if (reject_code_i != w.reject_code) begin
        report_mismatch($sformatf("result %0d: reject_code %0d, expected %0d",
                                  n_checked, reject_code_i, w.reject_code));
      end
      if (out_last_i != w.last) begin
        report_mismatch($sformatf("result %0d: out_last %0d, expected %0d",
                                  n_checked, out_last_i, w.last));
      end
    end
    n_checked++;
  endtask

  // Results leave no earlier than the cycle after their byte, so check before predicting.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      name_a = FIRST_NAME_RST;
      name_b = SECOND_NAME_RST;
      clear_msg();
      field_res_q.delete();
      n_awaiting = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        check_result();
      end
      if (in_valid_i && in_ready_i) begin
        parse_byte(in_byte_i, in_last_i);
      end
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_FIRST_NAME) begin
          name_a = cfg_data_i;
        end else begin
          name_b = cfg_data_i;
        end
      end
      n_awaiting = field_res_q.size();
    end
  end

endmodule

>>> sim/urlencoded_form_field_extractor_tb.sv
// ----------------------------------------------------------------------------
// urlencoded_form_field_extractor_tb
// Stimulus and verdict for the url-encoded form field extractor.
//
// Sends four hand-built form bodies with the reset names, then random bodies
// under several name settings: mostly well-formed pairs with matching and
// near-matching keys, escapes and '+', plus noise and broken tails. The sender
// works in bursts, the receiver stalls on changing patterns, and a checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module urlencoded_form_field_extractor_tb;
  import ufx_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 6;
  localparam int PHASE_ITEMS  = 75;

  // Receiver stall patterns.
  typedef enum int {RX_FREE, RX_COIN, RX_PERIODIC, RX_CHOKE} rx_mode_e;

  // Name register settings used by the random phases.
  typedef enum int {SET_MIXED, SET_EXTREME, SET_SAME, SET_FRESH} name_set_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  in_byte_i;
  logic        in_last_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  kind_o;
  logic [7:0]  data_byte_o;
  logic        field_id_o;
  logic        reject_code_o;
  logic        out_last_o;
  logic        cfg_we_i;
  logic        cfg_index_i;
  logic [63:0] cfg_data_i;

  int          fail_cnt;
  int          awaiting;
  int          cycle_cnt = 0;
  int          burst_left;
  int          sent;
  logic [7:0]  body_q[$];
  logic [63:0] cur_a;
  logic [63:0] cur_b;

  always #6 clk_i = ~clk_i;

  urlencoded_form_field_extractor DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_byte_i     (in_byte_i),
    .in_last_i     (in_last_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .data_byte_o   (data_byte_o),
    .field_id_o    (field_id_o),
    .reject_code_o (reject_code_o),
    .out_last_o    (out_last_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  ufx_field_checker field_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .in_byte_i     (in_byte_i),
    .in_last_i     (in_last_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_i        (kind_o),
    .data_byte_i   (data_byte_o),
    .field_id_i    (field_id_o),
    .reject_code_i (reject_code_o),
    .out_last_i    (out_last_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .fail_cnt_o    (fail_cnt),
    .awaiting_o    (awaiting)
  );

  // Receiver: each stretch picks a new stall pattern.
  initial begin : rx_stall
    rx_mode_e mode;
    int       span;
    int       k;
    out_ready_i = 1'b0;
    forever begin
      mode = rx_mode_e'($urandom_range(0, 3));
      span = $urandom_range(10, 80);
      for (k = 0; k < span; k++) begin
        @(negedge clk_i);
        case (mode)
          RX_FREE:     out_ready_i <= 1'b1;
          RX_COIN:     out_ready_i <= ($urandom_range(0, 1) == 1);
          RX_PERIODIC: out_ready_i <= (k % 4 == 0);
          default:     out_ready_i <= ($urandom_range(0, 9) == 0);
        endcase
      end
    end
  end

  // Run-away guard.
  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("FAIL urlencoded_form_field_extractor");
    $finish;
  end

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? 8'("0") + 8'(n) : 8'("A") - 8'd10 + 8'(n);
  endfunction

  function automatic logic [7:0] rand_letter();
    return 8'("a") + 8'($urandom_range(0, 5));
  endfunction

  // Names from a narrow alphabet, so random keys hit them now and then.
  function automatic logic [63:0] rand_name();
    logic [63:0] n;
    n = 64'd0;
    repeat (8) n = {n[55:0], rand_letter()};
    return n;
  endfunction

  // Send one byte as a request; bursts end in a random gap.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(1, 12);
      repeat (gap) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    in_last_i  <= fin;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Send the queued body with in_last on its final byte.
  task automatic send_body();
    int i;
    for (i = 0; i < body_q.size(); i++) begin
      send_byte(body_q[i], i == body_q.size() - 1);
    end
    sent += body_q.size();
    body_q.delete();
  endtask

  // Hold off the sender until every predicted result has come out.
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (awaiting != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    burst_left = 0;
  endtask

  task automatic write_name(input logic idx, input logic [63:0] v);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic add_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) body_q.push_back(8'(s[i]));
  endtask

  // Encode one decoded byte: '+' for some spaces, escapes for some bytes.
  task automatic add_char(input logic [7:0] c);
    int r;
    r = $urandom_range(0, 7);
    if (c == CHAR_SPACE && r < 4) begin
      body_q.push_back(CHAR_PLUS);
    end else if (c == CHAR_PLUS || c == CHAR_PERCENT || r == 0) begin
      body_q.push_back(CHAR_PERCENT);
      body_q.push_back(hex_char(c[7:4]));
      body_q.push_back(hex_char(c[3:0]));
    end else begin
      body_q.push_back(c);
    end
  endtask

  function automatic logic [7:0] value_char();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) begin
      return 8'("a") + 8'($urandom_range(0, 25));
    end else if (r == 6) begin
      return CHAR_SPACE;
    end
    return 8'($urandom_range(1, 255));
  endfunction

  // Build a body: mostly key=value pairs, sometimes noise or broken tails.
  task automatic build_body();
    int          pairs;
    int          pick;
    int          klen;
    int          p;
    int          i;
    logic [63:0] key;
    if ($urandom_range(0, 6) == 0) begin
      repeat ($urandom_range(1, 8)) body_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      pairs = $urandom_range(1, 3);
      for (p = 0; p < pairs; p++) begin
        if (p != 0) begin
          add_char(CHAR_AMP);
        end
        pick = $urandom_range(0, 19);
        klen = 8;
        if (pick < 8) begin
          key = cur_a;
        end else if (pick < 13) begin
          key = cur_b;
        end else if (pick < 16) begin
          // Near miss: one byte of a name changed.
          key = cur_a;
          key[8 * $urandom_range(0, 7) +: 8] = rand_letter();
        end else begin
          key  = rand_name();
          klen = $urandom_range(1, 10);
        end
        for (i = klen - 1; i >= 0; i--) begin
          add_char((i < 8) ? key[8 * i +: 8] : rand_letter());
        end
        if ($urandom_range(0, 11) != 0) begin
          add_char(CHAR_EQUALS);
        end
        repeat ($urandom_range(0, 4)) add_char(value_char());
      end
      case ($urandom_range(0, 9))
        0: body_q.push_back(CHAR_PERCENT);
        1: begin
          body_q.push_back(CHAR_PERCENT);
          body_q.push_back(hex_char(4'($urandom_range(0, 15))));
        end
        2: begin
          add_text("%00");
          body_q.push_back(8'($urandom_range(0, 255)));
        end
        3: body_q.push_back(8'($urandom_range(0, 255)));
        default: ;
      endcase
    end
  endtask

  initial begin : stimulus
    name_set_e set;
    int        s;
    int        phase_end;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_byte_i   = 8'd0;
    in_last_i   = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = CFG_FIRST_NAME;
    cfg_data_i  = 64'd0;
    burst_left  = 0;
    sent        = 0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset names: two matched pairs, '+', escapes, escaped delimiters,
    // an empty value and an end at a pair start.
    add_text("username=+%41&username%3D%26");
    send_body();
    // Delimiters as first key bytes, short key, bytes ignored after the end.
    add_text("&&=%4");
    send_body();
    // Top byte in a value, escape cut off by the last byte, end in a value.
    add_text("password=");
    body_q.push_back(8'hFF);
    add_text("%F");
    send_body();
    // A zero inside a key, then a byte that is ignored.
    add_text("x");
    body_q.push_back(CHAR_NUL);
    add_text("y");
    send_body();

    for (s = 0; s < 4; s++) begin
      set = name_set_e'(s);
      case (set)
        SET_MIXED: begin
          cur_a = rand_name();
          cur_b = rand_name();
        end
        SET_EXTREME: begin
          cur_a = {64{1'b1}};
          cur_b = 64'd0;
        end
        SET_SAME: begin
          cur_a = rand_name();
          cur_b = cur_a;
        end
        default: begin
          cur_a = rand_name();
          cur_b = FIRST_NAME_RST;
        end
      endcase
      write_name(CFG_FIRST_NAME, cur_a);
      write_name(CFG_SECOND_NAME, cur_b);
      phase_end = sent + PHASE_ITEMS;
      while (sent < phase_end) begin
        build_body();
        send_body();
        if ($urandom_range(0, 5) == 0) begin
          drain_results();
        end
      end
    end

    drain_results();
    if (fail_cnt == 0) begin
      $display("PASS urlencoded_form_field_extractor");
    end else begin
      $display("FAIL urlencoded_form_field_extractor");
    end
    $finish;
  end

endmodule
